>>> design/sobol_pkg.sv
// Shared types, sizes and request codes of the Sobol sequence generator.
package sobol_pkg;

	// Sizes
	localparam int DIMS       = 4;
	localparam int BITS       = 32;
	localparam int MAX_DEGREE = 8;

	localparam int DIM_W   = 2;
	localparam int DEG_W   = 4;
	localparam int POLY_W  = 7;
	localparam int INDEX_W = 4;
	localparam int MVAL_W  = 8;
	localparam int FUNC_W  = 3;
	localparam int IDX_W   = $clog2(BITS);
	localparam int ADDR_W  = DIM_W + IDX_W;
	localparam int DEPTH   = DIMS * BITS;
	localparam int GEN_W   = $clog2(BITS + 1);
	localparam int WIN_W   = $clog2(MAX_DEGREE);

	// Request codes
	localparam logic [FUNC_W-1:0] FN_SET     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BUILD   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DRAW    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RESTART = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [DIM_W-1:0]   dim;
		logic [DEG_W-1:0]   degree;
		logic [POLY_W-1:0]  poly;
		logic [INDEX_W-1:0] index;
		logic [MVAL_W-1:0]  m_value;
	} req_t;

	typedef struct packed {
		logic [DIM_W-1:0] out_dim;
		logic [BITS-1:0]  point;
		logic             last;
		logic             exhausted;
	} res_t;

endpackage

>>> design/sobol_sequence_generator.sv
// Sobol sequence generator: direction memory, build sequencer and draw engine.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------
//  request   | start / busy         | req    (func, dim, degree, ...)
//  result    | strobe, one cycle    | result (out_dim, point, last, exhausted)
//
// Set, load and restart complete on acceptance and leave busy low. A draw keeps busy
// high for one direction memory read per dimension plus the last write-back; results
// leave one per cycle. A build of degree s fills its window from memory, alternating
// read and capture states, then makes the other BITS-s direction numbers, one per
// cycle, each written through the single memory write port.
// Reset clears degrees, polynomials, points and counter; the direction memory is not
// cleared. Results cannot be held off by the receiver.
module sobol_sequence_generator
	import sobol_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic strobe,
	output res_t result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BRD  = 3'd1;
	localparam logic [2:0] S_BCAP = 3'd2;
	localparam logic [2:0] S_BGEN = 3'd3;
	localparam logic [2:0] S_DRAW = 3'd4;
	localparam logic [2:0] S_DEND = 3'd5;

	logic [2:0]        state_q;
	logic [DIM_W-1:0]  bdim_q;
	logic [DEG_W-1:0]  s_q;
	logic [POLY_W-1:0] a_q;
	logic [DEG_W-1:0]  ld_q;
	logic [GEN_W-1:0]  gi_q;
	logic [BITS-1:0]   win_q [MAX_DEGREE];
	logic [IDX_W-1:0]  e_q;
	logic              full_q;
	logic [DIM_W-1:0]  rd_d_q;
	logic              valid_s1;
	logic [DIM_W-1:0]  dim_s1;
	logic [BITS-1:0]   rdata_q;
	logic [BITS-1:0]   point_q [DIMS];
	logic [BITS-1:0]   cnt_q;
	logic [DEG_W-1:0]  degree_q [DIMS];
	logic [POLY_W-1:0] poly_q [DIMS];
	res_t              result_q;
	logic              strobe_q;

	logic [BITS-1:0] dir_mem [DEPTH];

	logic              acc;
	logic              dim_ok;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [BITS-1:0]   wdata;
	logic [ADDR_W-1:0] raddr;
	logic [BITS-1:0]   gen_v;
	logic [BITS-1:0]   low_zero;
	logic [IDX_W-1:0]  e_next;
	logic [BITS-1:0]   dir_s1;
	logic [BITS-1:0]   m_shifted;
	logic              idx_ok;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign dim_ok = (req.dim != '0) && (int'(req.dim) < DIMS);
	assign strobe = strobe_q;
	assign result = result_q;

	// Initial direction number placed at the top of the word
	assign idx_ok    = (req.index != '0) && (int'(req.index) <= MAX_DEGREE) &&
		(int'(req.index) <= BITS);
	assign m_shifted = BITS'(req.m_value) << (GEN_W'(BITS) - GEN_W'(req.index));

	// Recurrence over the window: win_q[0] is V[i-1], win_q[k-1] is V[i-k]
	always_comb begin
		logic [BITS-1:0] base;
		logic [WIN_W-1:0] ai;
		base  = win_q[WIN_W'(s_q - 1'b1)];
		gen_v = base ^ (base >> s_q);
		for (int k = 1; k < MAX_DEGREE; k++) begin
			ai = WIN_W'(int'(s_q) - 1 - k);
			if ((k < int'(s_q)) && a_q[ai])
				gen_v = gen_v ^ win_q[k-1];
		end
	end

	// Lowest zero bit of the counter, as one-hot and then encoded
	assign low_zero = ~cnt_q & BITS'(cnt_q + 1'b1);
	always_comb begin
		e_next = '0;
		for (int j = 0; j < BITS; j++)
			if (low_zero[j])
				e_next = e_next | IDX_W'(j);
	end

	// Direction number of the coordinate in the write-back stage
	assign dir_s1 = (dim_s1 == '0) ?
		(BITS'(1) << (IDX_W'(BITS - 1) - e_q)) : rdata_q;

	// Memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = {bdim_q, IDX_W'(gi_q - 1'b1)};
		wdata = gen_v;
		raddr = {rd_d_q, e_q};
		if (state_q == S_BGEN) begin
			we = 1'b1;
		end else if (acc && (req.func == FN_LOAD) && dim_ok && idx_ok) begin
			we    = 1'b1;
			waddr = {req.dim, IDX_W'(req.index - 1'b1)};
			wdata = m_shifted;
		end
		if (state_q == S_BRD)
			raddr = {bdim_q, IDX_W'(ld_q)};
	end

	// Direction memory, read data registered
	always_ff @(posedge clk) begin
		if (we)
			dir_mem[waddr] <= wdata;
		rdata_q <= dir_mem[raddr];
	end

	// Window registers of the build
	always_ff @(posedge clk) begin
		if (state_q == S_BCAP || state_q == S_BGEN) begin
			win_q[0] <= (state_q == S_BCAP) ? rdata_q : gen_v;
			for (int k = 1; k < MAX_DEGREE; k++)
				win_q[k] <= win_q[k-1];
		end
	end

	// Sequencer, draw pipeline and programmed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			bdim_q   <= '0;
			s_q      <= '0;
			a_q      <= '0;
			ld_q     <= '0;
			gi_q     <= '0;
			e_q      <= '0;
			full_q   <= 1'b0;
			rd_d_q   <= '0;
			valid_s1 <= 1'b0;
			dim_s1   <= '0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
			for (int d = 0; d < DIMS; d++) begin
				point_q[d]  <= '0;
				degree_q[d] <= '0;
				poly_q[d]   <= '0;
			end
		end else begin
			valid_s1 <= (state_q == S_DRAW);
			dim_s1   <= rd_d_q;
			strobe_q <= valid_s1;

			// Write-back stage of a draw
			if (valid_s1) begin
				if (!full_q) begin
					point_q[dim_s1] <= point_q[dim_s1] ^ dir_s1;
					if (int'(dim_s1) == DIMS - 1)
						cnt_q <= BITS'(cnt_q + 1'b1);
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.func)
							FN_SET: begin
								if (dim_ok) begin
									if (req.degree == '0)
										degree_q[req.dim] <= DEG_W'(1);
									else if (int'(req.degree) > MAX_DEGREE)
										degree_q[req.dim] <= DEG_W'(MAX_DEGREE);
									else
										degree_q[req.dim] <= req.degree;
									poly_q[req.dim] <= req.poly;
								end
							end
							FN_BUILD: begin
								if (dim_ok && degree_q[req.dim] != '0) begin
									bdim_q  <= req.dim;
									s_q     <= degree_q[req.dim];
									a_q     <= poly_q[req.dim];
									ld_q    <= '0;
									gi_q    <= GEN_W'(degree_q[req.dim]) + 1'b1;
									state_q <= S_BRD;
								end
							end
							FN_DRAW: begin
								e_q     <= e_next;
								full_q  <= (cnt_q == '1);
								rd_d_q  <= '0;
								state_q <= S_DRAW;
							end
							FN_RESTART: begin
								cnt_q <= '0;
								for (int d = 0; d < DIMS; d++)
									point_q[d] <= '0;
							end
							default: ;
						endcase
					end
				end
				S_BRD: begin
					state_q <= S_BCAP;
				end
				S_BCAP: begin
					ld_q <= ld_q + 1'b1;
					if (DEG_W'(ld_q + 1'b1) == s_q)
						state_q <= S_BGEN;
					else
						state_q <= S_BRD;
				end
				S_BGEN: begin
					gi_q <= gi_q + 1'b1;
					if (gi_q == GEN_W'(BITS))
						state_q <= S_IDLE;
				end
				S_DRAW: begin
					rd_d_q <= rd_d_q + 1'b1;
					if (int'(rd_d_q) == DIMS - 1)
						state_q <= S_DEND;
				end
				S_DEND: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.out_dim   <= dim_s1;
			result_q.point     <= point_q[dim_s1];
			result_q.last      <= (int'(dim_s1) == DIMS - 1);
			result_q.exhausted <= full_q;
		end
	end

`ifndef SYNTHESIS
	// The last coordinate closes a burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |=> !strobe_q)
		else $error("result after last coordinate");

	// Coordinates of one draw come in dimension order
	a_dim_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |=>
			strobe_q && (result_q.out_dim == DIM_W'($past(result_q.out_dim) + 1'b1)))
		else $error("coordinate out of order");

	// An exhausted draw leaves the counter full
	a_exhausted: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.exhausted |-> (cnt_q == '1))
		else $error("counter moved on exhausted draw");

	// Results only appear while a draw is finishing
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q) == S_DRAW || $past(state_q) == S_DEND)
		else $error("stray result strobe");
`endif

endmodule

>>> test/sobol_sequence_generator_test.sv
// Self-checking testbench for the Sobol sequence generator: request driver, coordinate monitor.
module sobol_sequence_generator_test;
	import sobol_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD     = 8;
	localparam int N_ITEMS    = 330;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_WAIT  = 64;

	// A queued request, optionally held back until all coordinates are out
	typedef struct packed {
		logic drain;
		req_t r;
	} pend_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic strobe;
	res_t result;

	pend_t request_q [$];
	res_t  coord_q [$];

	// Shadow generator state
	logic [BITS-1:0]   dir_tab [DIMS][BITS];
	logic [DEG_W-1:0]  deg_st [DIMS];
	logic [POLY_W-1:0] poly_st [DIMS];
	logic [BITS-1:0]   pt_st [DIMS];
	logic [BITS-1:0]   draw_cnt;

	int errors    = 0;
	int issued    = 0;
	int gap_left  = 0;
	int idle_cnt  = 0;

	sobol_sequence_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.result (result)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Update the shadow state for one accepted request; draws queue their coordinates
	task automatic predict_request(input req_t r);
		int s;
		int c;
		logic [BITS-1:0] v;
		logic [BITS-1:0] base;
		logic [BITS-1:0] step;
		logic full;
		res_t e;
		case (r.func)
			FN_SET: begin
				if (r.dim != 0) begin
					s = int'(r.degree);
					if (s == 0)
						s = 1;
					if (s > MAX_DEGREE)
						s = MAX_DEGREE;
					deg_st[r.dim]  = s[DEG_W-1:0];
					poly_st[r.dim] = r.poly;
				end
			end
			FN_LOAD: begin
				if (r.dim != 0 && r.index >= 1 && r.index <= MAX_DEGREE) begin
					v = {{(BITS - MVAL_W){1'b0}}, r.m_value};
					dir_tab[r.dim][r.index - 1] = v << (BITS - r.index);
				end
			end
			FN_BUILD: begin
				s = int'(deg_st[r.dim]);
				if (r.dim != 0 && s != 0) begin
					// recurrence over the window of the last s direction numbers
					for (int i = s + 1; i <= BITS; i++) begin
						base = dir_tab[r.dim][i - s - 1];
						v = base ^ (base >> s);
						for (int k = 1; k < s; k++)
							if (poly_st[r.dim][s - 1 - k])
								v ^= dir_tab[r.dim][i - k - 1];
						dir_tab[r.dim][i - 1] = v;
					end
				end
			end
			FN_DRAW: begin
				full = (draw_cnt == '1);
				for (int d = 0; d < DIMS; d++) begin
					e.out_dim   = d[DIM_W-1:0];
					e.point     = pt_st[d];
					e.last      = (d == DIMS - 1);
					e.exhausted = full;
					coord_q.push_back(e);
				end
				if (!full) begin
					// Gray-code step: lowest zero bit of the counter
					c = 1;
					v = draw_cnt;
					while (v[0] && c < BITS) begin
						v = v >> 1;
						c++;
					end
					for (int d = 0; d < DIMS; d++) begin
						if (d == 0)
							step = {{(BITS - 1){1'b0}}, 1'b1} << (BITS - c);
						else
							step = dir_tab[d][c - 1];
						pt_st[d] = pt_st[d] ^ step;
					end
					draw_cnt = draw_cnt + 1'b1;
				end
			end
			FN_RESTART: begin
				for (int d = 0; d < DIMS; d++)
					pt_st[d] = '0;
				draw_cnt = '0;
			end
			default: ;
		endcase
	endtask

	// Append a request
	task automatic queue_request(input logic [FUNC_W-1:0] func, input int dim, input int degree,
			input int poly, input int index, input int mval, input logic drain);
		pend_t p;
		p.drain     = drain;
		p.r.func    = func;
		p.r.dim     = dim[DIM_W-1:0];
		p.r.degree  = degree[DEG_W-1:0];
		p.r.poly    = poly[POLY_W-1:0];
		p.r.index   = index[INDEX_W-1:0];
		p.r.m_value = mval[MVAL_W-1:0];
		request_q.push_back(p);
	endtask

	// Request driver
	always @(posedge clk) begin : drive
		pend_t nxt;
		if (arst_n) begin
			if (start && !busy) begin
				predict_request(req);
				issued++;
				// every 64 requests, a stretch of 16 sent back to back
				gap_left = (issued % 64 < 16) ? 0 : $urandom_range(0, 19);
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (request_q.size() != 0 &&
						!(request_q[0].drain && coord_q.size() != 0)) begin
					nxt = request_q.pop_front();
					req   <= nxt.r;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Coordinate monitor
	always @(posedge clk) begin : monitor
		res_t e;
		if (arst_n && strobe) begin
			if (coord_q.size() == 0) begin
				$error("unexpected coordinate: out_dim %0d point %08h", result.out_dim,
					result.point);
				errors++;
			end else begin
				e = coord_q.pop_front();
				if (result.out_dim !== e.out_dim) begin
					$error("out_dim: expected %0d, got %0d", e.out_dim, result.out_dim);
					errors++;
				end
				if (result.point !== e.point) begin
					$error("point: expected %08h, got %08h", e.point, result.point);
					errors++;
				end
				if (result.last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, result.last);
					errors++;
				end
				if (result.exhausted !== e.exhausted) begin
					$error("exhausted: expected %0b, got %0b", e.exhausted, result.exhausted);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no request and no coordinate
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		int pick;
		int d;
		int s;
		logic drain_next;

		for (int i = 0; i < DIMS; i++) begin
			deg_st[i]  = '0;
			poly_st[i] = '0;
			pt_st[i]   = '0;
		end
		draw_cnt = '0;

		// Directed: build before set, unused codes, dimension zero
		queue_request(FN_BUILD, 1, 0, 0, 0, 0, 1'b0);
		for (int f = 5; f <= 7; f++)
			queue_request(f[FUNC_W-1:0], 3, 15, 127, 15, 255, 1'b0);
		queue_request(FN_SET, 0, 5, 127, 0, 0, 1'b0);
		queue_request(FN_LOAD, 0, 0, 0, 1, 1, 1'b0);

		// Dimension 1: degree zero clamps to one, out-of-range load indexes
		queue_request(FN_SET, 1, 0, 127, 0, 0, 1'b0);
		queue_request(FN_LOAD, 1, 0, 0, 0, 3, 1'b0);
		queue_request(FN_LOAD, 1, 0, 0, 15, 255, 1'b0);
		queue_request(FN_LOAD, 1, 0, 0, 1, 1, 1'b0);
		queue_request(FN_BUILD, 1, 0, 0, 0, 0, 1'b0);

		// Dimension 2: degree above the maximum, even and oversized m values
		queue_request(FN_SET, 2, 15, 0, 0, 0, 1'b0);
		for (int i = 1; i <= MAX_DEGREE; i++)
			queue_request(FN_LOAD, 2, 0, 0, i, (i % 2) ? 255 : (1 << (i - 1)), 1'b0);
		queue_request(FN_BUILD, 2, 0, 0, 0, 0, 1'b0);

		// Dimension 3: a proper degree-3 polynomial
		queue_request(FN_SET, 3, 3, 1, 0, 0, 1'b0);
		queue_request(FN_LOAD, 3, 0, 0, 1, 1, 1'b0);
		queue_request(FN_LOAD, 3, 0, 0, 2, 3, 1'b0);
		queue_request(FN_LOAD, 3, 0, 0, 3, 7, 1'b0);
		queue_request(FN_BUILD, 3, 0, 0, 0, 0, 1'b0);

		// Draws around a restart that waits for the coordinates to drain
		queue_request(FN_DRAW, 0, 0, 0, 0, 0, 1'b0);
		queue_request(FN_DRAW, 0, 0, 0, 0, 0, 1'b0);
		queue_request(FN_RESTART, 0, 0, 0, 0, 0, 1'b1);
		queue_request(FN_DRAW, 0, 0, 0, 0, 0, 1'b0);

		// Random: mostly draws and full reprogramming, some noise
		drain_next = 1'b0;
		while (request_q.size() < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				queue_request(FN_DRAW, $urandom_range(0, 3), $urandom_range(0, 15),
					$urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 255),
					drain_next);
			end else if (pick < 58) begin
				queue_request(FN_RESTART, 0, 0, 0, 0, 0, drain_next);
			end else if (pick < 70) begin
				// well-formed: set, odd m values below 2^i, build
				d = $urandom_range(1, DIMS - 1);
				s = $urandom_range(1, MAX_DEGREE);
				queue_request(FN_SET, d, s, $urandom_range(0, 127), 0, 0, drain_next);
				for (int i = 1; i <= s; i++)
					queue_request(FN_LOAD, d, 0, 0, i, $urandom_range(0, (1 << i) - 1) | 1,
						1'b0);
				queue_request(FN_BUILD, d, 0, 0, 0, 0, 1'b0);
			end else if (pick < 78) begin
				queue_request(FN_LOAD, $urandom_range(0, 3), $urandom_range(0, 15),
					$urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 255),
					drain_next);
			end else if (pick < 84) begin
				queue_request(FN_SET, $urandom_range(0, 3), $urandom_range(0, 15),
					$urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 255),
					drain_next);
			end else if (pick < 90) begin
				queue_request(FN_BUILD, $urandom_range(0, 3), $urandom_range(0, 15),
					$urandom_range(0, 127), 0, 0, drain_next);
			end else if (pick < 94) begin
				queue_request(FUNC_W'($urandom_range(5, 7)), $urandom_range(0, 3),
					$urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 15),
					$urandom_range(0, 255), drain_next);
			end else begin
				// broken: set, up to three arbitrary loads, build
				d = $urandom_range(0, DIMS - 1);
				queue_request(FN_SET, d, $urandom_range(0, 15), $urandom_range(0, 127), 0, 0,
					drain_next);
				repeat ($urandom_range(0, 3))
					queue_request(FN_LOAD, d, 0, 0, $urandom_range(0, 15),
						$urandom_range(0, 255), 1'b0);
				queue_request(FN_BUILD, d, 0, 0, 0, 0, 1'b0);
			end
			drain_next = ($urandom_range(0, 49) == 0);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every coordinate to come out
		while (request_q.size() != 0 || start || coord_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		// Nothing may be left pending after the tail
		if (request_q.size() != 0 || start || coord_q.size() != 0) begin
			$error("pending at end: %0d requests, %0d coordinates", request_q.size(),
				coord_q.size());
			errors++;
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
design/sobol_pkg.sv
design/sobol_sequence_generator.sv
test/sobol_sequence_generator_test.sv
